@@ design/pta_pkg.sv @@
// Package for the primitive topology assembler.
// Holds the index width constants, mode and register codes, and the result type.
// No dependencies.
package pta_pkg;

    // Width of a vertex index inside the assembler (8 to 64)
    localparam int INDEX_WIDTH = 32;
    // Only the low 32 bits of an index ever reach a result field
    localparam int VERT_W = (INDEX_WIDTH < 32) ? INDEX_WIDTH : 32;

    localparam int FIELD_W = 32;
    localparam int CFG_IDX_W = 2;

    // Topology modes
    localparam logic [2:0] MODE_TRI_LIST  = 3'd0;
    localparam logic [2:0] MODE_TRI_STRIP = 3'd1;
    localparam logic [2:0] MODE_TRI_FAN   = 3'd2;
    localparam logic [2:0] MODE_LINE_LIST = 3'd3;
    localparam logic [2:0] MODE_LINE_STRIP = 3'd4;
    localparam logic [2:0] MODE_LINE_LOOP = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRIM_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_INDEX_LIST = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_INDEX    = 2'd3;

    // One assembled primitive
    typedef struct packed {
        logic [FIELD_W-1:0] idx_a;
        logic [FIELD_W-1:0] idx_b;
        logic [FIELD_W-1:0] idx_c;
        logic [FIELD_W-1:0] prim_number;
        logic               run_last;
    } result_t;

endpackage

@@ design/primitive_topology_assembler.sv @@
// Primitive topology assembler top level.
// Depends on pta_pkg for widths, mode and register codes and the result type.
//
// One vertex is taken per transfer, one every cycle while in_ready is high.
// The vertex index comes from vertex_index, or from start_index plus the
// position in the draw when indexing is off. Primitives of the configured mode
// are built from the running first, older and newer vertices and are written
// straight into a two-entry result buffer. Every vertex yields at most one
// primitive except the closing vertex of a line loop, which yields two; the
// buffer then drains one result per cycle while out_ready is high. in_ready
// follows out_ready within the cycle: it is high when the buffer, after this
// cycle's output transfer, has room for every result the offered vertex will
// cause. Configuration writes are always taken and act from the next vertex on.
module primitive_topology_assembler
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pta_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pta_pkg::FIELD_W-1:0]    cfg_data,

    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [pta_pkg::FIELD_W-1:0]    vertex_index,

    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [pta_pkg::FIELD_W-1:0]    idx_a,
    output logic [pta_pkg::FIELD_W-1:0]    idx_b,
    output logic [pta_pkg::FIELD_W-1:0]    idx_c,
    output logic [pta_pkg::FIELD_W-1:0]    prim_number,
    output logic                           run_last
);

    localparam int VW = pta_pkg::VERT_W;
    localparam int FW = pta_pkg::FIELD_W;

    // Configuration registers
    logic [2:0]    prim_mode_reg;
    logic [FW-1:0] vertex_count_reg;
    logic          use_index_list_reg;
    logic [FW-1:0] start_index_reg;

    // Draw state
    logic [FW-1:0] position_reg;
    logic [1:0]    pos_mod3_reg;
    logic [VW-1:0] first_vertex_reg;
    logic [VW-1:0] older_vertex_reg;
    logic [VW-1:0] newer_vertex_reg;
    logic [FW-1:0] prim_counter_reg;

    // Result buffer: entry 0 is the head shown on the output
    pta_pkg::result_t slot_reg [2];
    logic [1:0]       count_reg;

    pta_pkg::result_t slot_next [2];
    logic [1:0]       count_next;

    logic          draw_active;
    logic          accept;
    logic          pop;
    logic [FW-1:0] idx_sum;
    logic [VW-1:0] vert;
    logic [VW-1:0] first_eff;
    logic [FW-1:0] prim_eff;
    logic          pos_zero;
    logic          pos_ge1;
    logic          pos_ge2;
    logic          is_last;
    logic          emit0;
    logic          emit1;
    logic [1:0]    need;
    logic [1:0]    free_slots;
    logic [FW-1:0] res0_a;
    logic [FW-1:0] res0_b;
    logic [FW-1:0] res0_c;
    pta_pkg::result_t res0;
    pta_pkg::result_t res1;
    logic [FW-1:0] prim_next;
    logic [1:0]    mod3_next;

    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prim_mode_reg      <= pta_pkg::MODE_TRI_LIST;
            vertex_count_reg   <= '0;
            use_index_list_reg <= 1'b0;
            start_index_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pta_pkg::CFG_PRIM_MODE:      prim_mode_reg      <= cfg_data[2:0];
                pta_pkg::CFG_VERTEX_COUNT:   vertex_count_reg   <= cfg_data;
                pta_pkg::CFG_USE_INDEX_LIST: use_index_list_reg <= cfg_data[0];
                pta_pkg::CFG_START_INDEX:    start_index_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Current vertex and position flags
    always_comb
    begin
        draw_active = (vertex_count_reg != '0);
        idx_sum     = start_index_reg + position_reg;
        vert        = use_index_list_reg ? vertex_index[VW-1:0] : idx_sum[VW-1:0];
        pos_zero    = (position_reg == '0);
        pos_ge1     = !pos_zero;
        pos_ge2     = |position_reg[FW-1:1];
        is_last     = ({1'b0, position_reg} + 33'd1) == {1'b0, vertex_count_reg};
        first_eff   = pos_zero ? vert : first_vertex_reg;
        prim_eff    = pos_zero ? '0 : prim_counter_reg;
    end

    // Primitive selection by mode
    always_comb
    begin
        emit0  = 1'b0;
        emit1  = 1'b0;
        res0_a = FW'(older_vertex_reg);
        res0_b = FW'(newer_vertex_reg);
        res0_c = FW'(vert);
        case (prim_mode_reg)
            pta_pkg::MODE_TRI_LIST:
            begin
                emit0 = (pos_mod3_reg == 2'd2);
            end
            pta_pkg::MODE_TRI_STRIP:
            begin
                emit0 = pos_ge2;
                if (prim_eff[0])
                begin
                    res0_a = FW'(newer_vertex_reg);
                    res0_b = FW'(older_vertex_reg);
                end
            end
            pta_pkg::MODE_TRI_FAN:
            begin
                emit0  = pos_ge2;
                res0_a = FW'(first_eff);
            end
            pta_pkg::MODE_LINE_LIST:
            begin
                emit0  = position_reg[0];
                res0_a = FW'(newer_vertex_reg);
                res0_b = FW'(vert);
                res0_c = '0;
            end
            pta_pkg::MODE_LINE_STRIP:
            begin
                emit0  = pos_ge1;
                res0_a = FW'(newer_vertex_reg);
                res0_b = FW'(vert);
                res0_c = '0;
            end
            pta_pkg::MODE_LINE_LOOP:
            begin
                emit0  = pos_ge1;
                emit1  = pos_ge1 && is_last;
                res0_a = FW'(newer_vertex_reg);
                res0_b = FW'(vert);
                res0_c = '0;
            end
            default: ;
        endcase
        if (!draw_active)
        begin
            emit0 = 1'b0;
            emit1 = 1'b0;
        end
    end

    // Result words; the closing line of a loop follows the last segment
    always_comb
    begin
        res0.idx_a       = res0_a;
        res0.idx_b       = res0_b;
        res0.idx_c       = res0_c;
        res0.prim_number = prim_eff;
        res0.run_last    = !emit1;
        res1.idx_a       = FW'(vert);
        res1.idx_b       = FW'(first_eff);
        res1.idx_c       = '0;
        res1.prim_number = prim_eff + FW'(1);
        res1.run_last    = 1'b1;
        need             = {1'b0, emit0} + {1'b0, emit1};
    end

    // Flow control: room after this cycle's output transfer
    always_comb
    begin
        pop        = (count_reg != 2'd0) && out_ready;
        free_slots = 2'd2 - count_reg + {1'b0, pop};
        in_ready   = (need <= free_slots);
        accept     = in_valid && in_ready;
    end

    // Result buffer update
    always_comb
    begin
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        count_next   = count_reg;
        if (pop)
        begin
            slot_next[0] = slot_reg[1];
            count_next   = count_reg - 2'd1;
        end
        if (accept && emit0)
        begin
            if (count_next == 2'd0)
            begin
                slot_next[0] = res0;
            end
            else
            begin
                slot_next[1] = res0;
            end
            count_next = count_next + 2'd1;
            if (emit1)
            begin
                slot_next[1] = res1;
                count_next   = count_next + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Payload slots carry no reset
    always_ff @(posedge clk)
    begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

    // Next draw state
    always_comb
    begin
        prim_next = is_last ? '0 : (prim_eff + FW'(need));
        if (is_last || (position_reg == '1))
        begin
            mod3_next = 2'd0;
        end
        else if (pos_mod3_reg == 2'd2)
        begin
            mod3_next = 2'd0;
        end
        else
        begin
            mod3_next = pos_mod3_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg     <= '0;
            pos_mod3_reg     <= 2'd0;
            first_vertex_reg <= '0;
            older_vertex_reg <= '0;
            newer_vertex_reg <= '0;
            prim_counter_reg <= '0;
        end
        else if (accept && draw_active)
        begin
            position_reg     <= is_last ? '0 : (position_reg + FW'(1));
            pos_mod3_reg     <= mod3_next;
            first_vertex_reg <= first_eff;
            older_vertex_reg <= newer_vertex_reg;
            newer_vertex_reg <= vert;
            prim_counter_reg <= prim_next;
        end
    end

    // Output port drive
    assign out_valid   = (count_reg != 2'd0);
    assign idx_a       = slot_reg[0].idx_a;
    assign idx_b       = slot_reg[0].idx_b;
    assign idx_c       = slot_reg[0].idx_c;
    assign prim_number = slot_reg[0].prim_number;
    assign run_last    = slot_reg[0].run_last;

endmodule
